[rtl/wang_landau_histogram_defines.svh]
// ----------------------------------------------------------------------------
// Wang-Landau histogram assertion macros
// Shared property forms for the checker of the histogram block.
// ----------------------------------------------------------------------------
`ifndef WANG_LANDAU_HISTOGRAM_DEFINES_SVH
`define WANG_LANDAU_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define WLH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define WLH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/wlh_pkg.sv]
// ----------------------------------------------------------------------------
// Wang-Landau histogram package
// Sizes, codes and shared types of the histogram block.
// ----------------------------------------------------------------------------
package wlh_pkg;

    localparam int NUM_BINS = 256;
    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int KNOWN_W  = $clog2(NUM_BINS + 1);
    localparam int COUNT_W  = 32;
    localparam int LOG_W    = 40;
    localparam int FACTOR_W = 25;
    localparam int CRIT_W   = 16;
    localparam int ACTION_W = 2;
    localparam int SUM_W    = COUNT_W + KNOWN_W;
    localparam int PROD_W   = COUNT_W + KNOWN_W;
    localparam int CMP_W    = CRIT_W + SUM_W;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [CRIT_W-1:0] CRIT_RESET = 16'd52429;

    typedef enum logic [ACTION_W-1:0] {
        ACT_UPDATE = 2'd0,
        ACT_CHECK  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_UPDATE,
        BS_SCAN,
        BS_MULT,
        BS_COMPARE
    } back_state_t;

    typedef struct packed {
        action_t               action;
        logic                  in_range;
        logic [BIN_W-1:0]      bin;
        logic [FACTOR_W-1:0]   factor;
    } cmd_t;

    typedef struct packed {
        logic                  is_flat;
        logic [7:0]            min_bin;
        logic [7:0]            max_bin;
        logic [LOG_W-1:0]      bin_log_dos;
    } rsp_t;

    function automatic logic [7:0] to_bin8(input logic [BIN_W-1:0] b);
        logic [BIN_W+7:0] w;
        w = {8'b0, b};
        return w[7:0];
    endfunction

endpackage

[rtl/wlh_if.sv]
// ----------------------------------------------------------------------------
// Wang-Landau histogram channels
// Valid/ready interfaces for the command, result and configuration channels.
// ----------------------------------------------------------------------------
interface wlh_cmd_if import wlh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [7:0]          bin_index;
    logic [FACTOR_W-1:0] log_factor;

    modport source (output valid, output action, output bin_index, output log_factor,
                    input ready);
    modport sink   (input valid, input action, input bin_index, input log_factor,
                    output ready);
endinterface

interface wlh_rsp_if import wlh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             is_flat;
    logic [7:0]       min_bin;
    logic [7:0]       max_bin;
    logic [LOG_W-1:0] bin_log_dos;

    modport source (output valid, output is_flat, output min_bin, output max_bin,
                    output bin_log_dos, input ready);
    modport sink   (input valid, input is_flat, input min_bin, input max_bin,
                    input bin_log_dos, output ready);
endinterface

interface wlh_cfg_if import wlh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CRIT_W-1:0] flat_criteria;

    modport source (output valid, output flat_criteria, input ready);
    modport sink   (input valid, input flat_criteria, output ready);
endinterface

[rtl/wlh_front.sv]
// ----------------------------------------------------------------------------
// Wang-Landau histogram front end
// Accepts command transactions, classifies them and buffers them in a queue.
// ----------------------------------------------------------------------------
module wlh_front
    import wlh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    wlh_cmd_if.sink      cmd,
    input  logic         q_pop,
    output logic         q_valid,
    output cmd_t         q_entry
);

    cmd_t              qbuf_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [BIN_W+7:0]  wide_bin;
    cmd_t              classified;
    logic              push;

    assign cmd.ready = (count_reg != QCNT_W'(QDEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != '0);
    assign q_entry   = qbuf_reg[rd_ptr_reg];

    always_comb
    begin
        wide_bin            = {{BIN_W{1'b0}}, cmd.bin_index};
        classified.action   = action_t'(cmd.action);
        classified.in_range = (wide_bin < (BIN_W + 8)'(NUM_BINS));
        classified.bin      = wide_bin[BIN_W-1:0];
        classified.factor   = cmd.log_factor;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qbuf_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

[rtl/wlh_back.sv]
// ----------------------------------------------------------------------------
// Wang-Landau histogram back end
// Executes queued commands against the bin memories and registers results.
// ----------------------------------------------------------------------------
module wlh_back
    import wlh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CRIT_W-1:0] criteria,
    input  logic              q_valid,
    input  cmd_t              q_entry,
    output logic              q_pop,
    wlh_rsp_if.source         rsp
);

    logic [COUNT_W-1:0]  cnt_mem [NUM_BINS];
    logic [LOG_W-1:0]    dos_mem [NUM_BINS];
    logic [COUNT_W-1:0]  cnt_rd_reg;
    logic [LOG_W-1:0]    dos_rd_reg;
    logic [BIN_W-1:0]    rd_addr;
    logic [BIN_W-1:0]    wr_addr;
    logic                mem_we;
    logic [COUNT_W-1:0]  cnt_wdata;
    logic [LOG_W-1:0]    dos_wdata;

    back_state_t         state_reg;
    back_state_t         state_next;
    cmd_t                cur_reg;
    cmd_t                cur_next;
    logic [BIN_W-1:0]    scan_idx_reg;
    logic [BIN_W-1:0]    scan_idx_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [KNOWN_W-1:0]  known_reg;
    logic [KNOWN_W-1:0]  known_next;
    logic [COUNT_W-1:0]  lo_val_reg;
    logic [COUNT_W-1:0]  lo_val_next;
    logic [COUNT_W-1:0]  hi_val_reg;
    logic [COUNT_W-1:0]  hi_val_next;
    logic [BIN_W-1:0]    lo_bin_reg;
    logic [BIN_W-1:0]    lo_bin_next;
    logic [BIN_W-1:0]    hi_bin_reg;
    logic [BIN_W-1:0]    hi_bin_next;
    logic                seen_reg;
    logic                seen_next;
    logic [PROD_W-1:0]   prod_a_reg;
    logic [PROD_W-1:0]   prod_a_next;
    logic [CMP_W-1:0]    prod_b_reg;
    logic [CMP_W-1:0]    prod_b_next;
    logic [BIN_W-1:0]    low_bin_reg;
    logic [BIN_W-1:0]    low_bin_next;
    logic [BIN_W-1:0]    high_bin_reg;
    logic [BIN_W-1:0]    high_bin_next;
    logic [NUM_BINS-1:0] visited_reg;
    logic [NUM_BINS-1:0] visited_next;
    logic [NUM_BINS-1:0] cnt_ok_reg;
    logic [NUM_BINS-1:0] cnt_ok_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    rsp_t                out_reg;
    rsp_t                out_next;
    logic                can_issue;

    assign can_issue = !out_valid_reg || rsp.ready;
    assign q_pop     = (state_reg == BS_IDLE) && q_valid && can_issue;

    assign rsp.valid       = out_valid_reg;
    assign rsp.is_flat     = out_reg.is_flat;
    assign rsp.min_bin     = out_reg.min_bin;
    assign rsp.max_bin     = out_reg.max_bin;
    assign rsp.bin_log_dos = out_reg.bin_log_dos;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_entry.action)
                        ACT_UPDATE: state_next = q_entry.in_range ? BS_UPDATE : BS_IDLE;
                        ACT_CHECK:  state_next = BS_SCAN;
                        default:    state_next = BS_IDLE;
                    endcase
                end
            end
            BS_UPDATE:
            begin
                state_next = BS_IDLE;
            end
            BS_SCAN:
            begin
                if (scan_idx_reg == BIN_W'(NUM_BINS - 1))
                begin
                    state_next = BS_MULT;
                end
            end
            BS_MULT:
            begin
                state_next = BS_COMPARE;
            end
            BS_COMPARE:
            begin
                state_next = BS_IDLE;
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic [BIN_W-1:0]   idx;
        logic [COUNT_W-1:0] cnt_old;
        logic [LOG_W-1:0]   dos_old;
        logic [LOG_W:0]     dos_sum;
        logic [COUNT_W-1:0] c;
        logic [BIN_W-1:0]   res_lo;
        logic [BIN_W-1:0]   res_hi;

        idx           = '0;
        cnt_old       = '0;
        dos_old       = '0;
        dos_sum       = '0;
        c             = '0;
        res_lo        = '0;
        res_hi        = '0;
        cur_next      = cur_reg;
        scan_idx_next = scan_idx_reg;
        sum_next      = sum_reg;
        known_next    = known_reg;
        lo_val_next   = lo_val_reg;
        hi_val_next   = hi_val_reg;
        lo_bin_next   = lo_bin_reg;
        hi_bin_next   = hi_bin_reg;
        seen_next     = seen_reg;
        prod_a_next   = prod_a_reg;
        prod_b_next   = prod_b_reg;
        low_bin_next  = low_bin_reg;
        high_bin_next = high_bin_reg;
        visited_next  = visited_reg;
        cnt_ok_next   = cnt_ok_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next      = out_reg;
        rd_addr       = q_entry.bin;
        wr_addr       = cur_reg.bin;
        mem_we        = 1'b0;
        cnt_wdata     = '0;
        dos_wdata     = '0;

        case (state_reg)
            BS_IDLE:
            begin
                if (q_pop)
                begin
                    cur_next = q_entry;
                    out_next.is_flat     = 1'b0;
                    out_next.min_bin     = to_bin8(low_bin_reg);
                    out_next.max_bin     = to_bin8(high_bin_reg);
                    out_next.bin_log_dos = '0;
                    case (q_entry.action)
                        ACT_UPDATE:
                        begin
                            out_valid_next = !q_entry.in_range;
                        end
                        ACT_CHECK:
                        begin
                            rd_addr       = '0;
                            scan_idx_next = '0;
                            sum_next      = '0;
                            known_next    = '0;
                            seen_next     = 1'b0;
                        end
                        ACT_CLEAR:
                        begin
                            cnt_ok_next    = '0;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            BS_UPDATE:
            begin
                idx     = cur_reg.bin;
                cnt_old = cnt_ok_reg[idx] ? cnt_rd_reg : '0;
                dos_old = visited_reg[idx] ? dos_rd_reg : '0;
                dos_sum = {1'b0, dos_old} + (LOG_W + 1)'(cur_reg.factor);
                cnt_wdata = (cnt_old == '1) ? cnt_old : cnt_old + 1'b1;
                dos_wdata = dos_sum[LOG_W] ? '1 : dos_sum[LOG_W-1:0];
                mem_we    = 1'b1;
                wr_addr   = idx;
                visited_next[idx] = 1'b1;
                cnt_ok_next[idx]  = 1'b1;
                out_valid_next       = 1'b1;
                out_next.bin_log_dos = dos_wdata;
            end
            BS_SCAN:
            begin
                idx           = scan_idx_reg;
                rd_addr       = scan_idx_reg + 1'b1;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (visited_reg[idx])
                begin
                    c          = cnt_ok_reg[idx] ? cnt_rd_reg : '0;
                    sum_next   = sum_reg + SUM_W'(c);
                    known_next = known_reg + 1'b1;
                    seen_next  = 1'b1;
                    if (!seen_reg)
                    begin
                        lo_val_next = c;
                        hi_val_next = c;
                        lo_bin_next = idx;
                        hi_bin_next = idx;
                    end
                    else
                    begin
                        if (c < lo_val_reg)
                        begin
                            lo_val_next = c;
                            lo_bin_next = idx;
                        end
                        if (c > hi_val_reg)
                        begin
                            hi_val_next = c;
                            hi_bin_next = idx;
                        end
                    end
                end
            end
            BS_MULT:
            begin
                prod_a_next = lo_val_reg * known_reg;
                prod_b_next = criteria * sum_reg;
            end
            BS_COMPARE:
            begin
                res_lo = seen_reg ? lo_bin_reg : low_bin_reg;
                res_hi = seen_reg ? hi_bin_reg : high_bin_reg;
                low_bin_next  = res_lo;
                high_bin_next = res_hi;
                out_valid_next       = 1'b1;
                out_next.is_flat     = seen_reg && ({prod_a_reg, {CRIT_W{1'b0}}} > prod_b_reg);
                out_next.min_bin     = to_bin8(res_lo);
                out_next.max_bin     = to_bin8(res_hi);
                out_next.bin_log_dos = '0;
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            low_bin_reg   <= '0;
            high_bin_reg  <= '0;
            visited_reg   <= '0;
            cnt_ok_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_bin_reg   <= low_bin_next;
            high_bin_reg  <= high_bin_next;
            visited_reg   <= visited_next;
            cnt_ok_reg    <= cnt_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        scan_idx_reg <= scan_idx_next;
        sum_reg      <= sum_next;
        known_reg    <= known_next;
        lo_val_reg   <= lo_val_next;
        hi_val_reg   <= hi_val_next;
        lo_bin_reg   <= lo_bin_next;
        hi_bin_reg   <= hi_bin_next;
        seen_reg     <= seen_next;
        prod_a_reg   <= prod_a_next;
        prod_b_reg   <= prod_b_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[wr_addr] <= cnt_wdata;
            dos_mem[wr_addr] <= dos_wdata;
        end
        cnt_rd_reg <= cnt_mem[rd_addr];
        dos_rd_reg <= dos_mem[rd_addr];
    end

endmodule

[rtl/wang_landau_histogram.sv]
// ----------------------------------------------------------------------------
// Wang-Landau histogram table
// Keeps a visit count and a Q16.24 log density of states for each of NUM_BINS
// bins and answers update, flatness check and clear commands with one result
// transaction each. A front end takes commands into a two-entry queue, so it
// keeps accepting, until the queue is full, while the back end works or while
// a result waits to be taken. The back end handles one command at a time: an
// in-range update does a registered read of the bin memories, then the
// write-back; a check reads one bin per cycle through the count memory's read
// port and then multiplies and compares; a clear or an unused command code is
// answered from the idle state. Visit counts and log densities are valid
// immediately after reset, with no clearing pass. The flatness criteria
// register resets to 52429 and is written through the cfg channel.
// ----------------------------------------------------------------------------
module wang_landau_histogram
    import wlh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wlh_cmd_if.sink    cmd,
    wlh_rsp_if.source  rsp,
    wlh_cfg_if.sink    cfg
);

    logic [CRIT_W-1:0] crit_reg;
    logic [CRIT_W-1:0] crit_next;
    logic              q_valid;
    logic              q_pop;
    cmd_t              q_entry;

    assign cfg.ready = 1'b1;
    assign crit_next = (cfg.valid && cfg.ready) ? cfg.flat_criteria : crit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_reg <= CRIT_RESET;
        end
        else
        begin
            crit_reg <= crit_next;
        end
    end

    wlh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_entry (q_entry)
    );

    wlh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .criteria (crit_reg),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .rsp      (rsp)
    );

endmodule

[rtl/wlh_checker.sv]
// ----------------------------------------------------------------------------
// Wang-Landau histogram port checker
// Watches the command and result channels of the histogram block.
// ----------------------------------------------------------------------------
`include "wang_landau_histogram_defines.svh"

module wlh_checker
    import wlh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_ready,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  logic             is_flat,
    input  logic [7:0]       min_bin,
    input  logic [7:0]       max_bin,
    input  logic [LOG_W-1:0] bin_log_dos
);

    localparam int MAX_PENDING = QDEPTH + 2;

    logic [3:0] pend_reg;
    logic [3:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if ((cmd_valid && cmd_ready) && !(rsp_valid && rsp_ready))
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!(cmd_valid && cmd_ready) && (rsp_valid && rsp_ready))
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A result is only offered for a command that has been accepted.
    `WLH_ASSERT_IMP(a_rsp_has_cmd, rsp_valid, pend_reg != 4'd0, "result without a command")

    // The queue, the back end and the output register bound the open commands.
    `WLH_ASSERT_IMP(a_pend_bound, 1'b1, pend_reg <= 4'(MAX_PENDING), "too many open commands")

    // Only an update reports a log density, and only a check reports flat.
    `WLH_ASSERT_IMP(a_flat_no_dos, rsp_valid && (bin_log_dos != '0), !is_flat, "flat with density")

    `WLH_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(is_flat) && $stable(min_bin) && $stable(max_bin) && $stable(bin_log_dos), "stalled result changed")

endmodule

bind wang_landau_histogram wlh_checker u_wlh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .is_flat     (rsp.is_flat),
    .min_bin     (rsp.min_bin),
    .max_bin     (rsp.max_bin),
    .bin_log_dos (rsp.bin_log_dos)
);
